/* src/floyd_steinberg_dither_8color_top_defines.svh */
// Assertion macros shared by the dither RTL.
// Each expects clk and rst in scope.
`ifndef FLOYD_STEINBERG_DITHER_8COLOR_TOP_DEFINES_SVH
`define FLOYD_STEINBERG_DITHER_8COLOR_TOP_DEFINES_SVH

// Condition in this cycle implies consequence in the next cycle.
`define FSD_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("fsd: next-cycle check failed");

// Condition implies consequence in the same cycle.
`define FSD_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("fsd: same-cycle check failed");

`endif

/* src/fsd_pkg.sv */
package fsd_pkg;

  localparam int PIX_W      = 8;
  localparam int ERR_W      = 9;
  localparam int PACK_W     = 3 * ERR_W;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int DEF_MAX_WIDTH = 2048;

  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 12'd640;
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 16'd480;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // {red, green, blue} corner bits to palette index
  localparam logic [2:0] PAL_INDEX [8] = '{3'd0, 3'd3, 3'd2, 3'd6,
                                           3'd1, 3'd5, 3'd4, 3'd7};

  typedef struct packed {
    logic top;
    logic has_left;
    logic has_ur;
  } pos_t;

  typedef struct packed {
    logic use_ul;
    logic use_up;
    logic use_ur;
    logic use_lf;
  } chan_en_t;

endpackage

/* src/fsd_ram.sv */
module fsd_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/fsd_chan.sv */
module fsd_chan (
  input  logic [fsd_pkg::PIX_W-1:0]        pix,
  input  logic signed [fsd_pkg::ERR_W-1:0] ul,
  input  logic signed [fsd_pkg::ERR_W-1:0] up,
  input  logic signed [fsd_pkg::ERR_W-1:0] ur,
  input  logic signed [fsd_pkg::ERR_W-1:0] lf,
  input  fsd_pkg::chan_en_t                en,
  output logic                             hi,
  output logic signed [fsd_pkg::ERR_W-1:0] err
);

  import fsd_pkg::*;

  localparam logic [2:0] FAC_UL = 3'd1;
  localparam logic [2:0] FAC_UP = 3'd5;
  localparam logic [2:0] FAC_UR = 3'd3;
  localparam logic [2:0] FAC_LF = 3'd7;

  // v + (e * fac) / 16 rounded toward zero, clamped to 0..255
  function automatic logic [PIX_W-1:0] add_term(input logic [PIX_W-1:0] v,
                                                input logic signed [ERR_W-1:0] e,
                                                input logic [2:0] fac);
    logic signed [12:0] p;
    logic signed [12:0] q;
    logic signed [12:0] n;
    logic [PIX_W-1:0]   r;
    p = $signed({{4{e[ERR_W-1]}}, e}) * $signed({10'd0, fac});
    q = p[12] ? (p + 13'sd15) : p;
    n = $signed({5'd0, v}) + (q >>> 4);
    if (n[12]) begin
      r = '0;
    end else if (n > 13'sd255) begin
      r = '1;
    end else begin
      r = n[PIX_W-1:0];
    end
    return r;
  endfunction

  logic [PIX_W-1:0] v1, v2, v3, v4;

  always_comb begin
    v1 = en.use_ul ? add_term(pix, ul, FAC_UL) : pix;
    v2 = en.use_up ? add_term(v1, up, FAC_UP) : v1;
    v3 = en.use_ur ? add_term(v2, ur, FAC_UR) : v2;
    v4 = en.use_lf ? add_term(v3, lf, FAC_LF) : v3;
  end

  assign hi  = v4[PIX_W-1];
  assign err = $signed({1'b0, v4}) - (hi ? 9'sd255 : 9'sd0);

endmodule

/* src/fsd_ctrl.sv */
`include "floyd_steinberg_dither_8color_top_defines.svh"

module fsd_ctrl #(
  parameter int MAX_WIDTH = fsd_pkg::DEF_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fsd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            step,
  output fsd_pkg::pos_t                   pos,
  output logic [$clog2(MAX_WIDTH)-1:0]    x,
  output logic [$clog2(MAX_WIDTH)-1:0]    raddr
);

  import fsd_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CMP_W = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;

  logic [WIDTH_W-1:0]  image_width, image_width_next;
  logic [HEIGHT_W-1:0] image_height, image_height_next;
  logic [COL_W-1:0]    col, col_next;
  logic [HEIGHT_W-1:0] row, row_next;

  logic [CMP_W-1:0]    w_cur, w_nx, x1, xn, rd;
  logic [HEIGHT_W-1:0] h_cur, y, row_after;
  logic [HEIGHT_W:0]   row_inc, row_adv;
  logic                col_wrap;

  function automatic logic [CMP_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
    logic [CMP_W-1:0] e;
    e = CMP_W'(w);
    if (e == '0) begin
      e = CMP_W'(1);
    end else if (e > CMP_W'(MAX_WIDTH)) begin
      e = CMP_W'(MAX_WIDTH);
    end
    return e;
  endfunction

  always_comb begin
    w_cur    = eff_width(image_width);
    h_cur    = (image_height == '0) ? HEIGHT_W'(1) : image_height;
    // a column past the width starts the next row
    col_wrap = CMP_W'(col) >= w_cur;
    x        = col_wrap ? '0 : col;
    row_inc  = {1'b0, row} + (HEIGHT_W + 1)'(col_wrap);
    y        = (row_inc >= {1'b0, h_cur}) ? '0 : row_inc[HEIGHT_W-1:0];
    x1       = CMP_W'(x) + CMP_W'(1);
    row_adv  = {1'b0, y} + (HEIGHT_W + 1)'(1);
    row_after = (row_adv >= {1'b0, h_cur}) ? '0 : row_adv[HEIGHT_W-1:0];

    pos.top      = (y != '0);
    pos.has_left = (x != '0);
    pos.has_ur   = pos.top && (x1 < w_cur);

    col_next = col;
    row_next = row;
    if (step) begin
      if (x1 >= w_cur) begin
        col_next = '0;
        row_next = row_after;
      end else begin
        col_next = x1[COL_W-1:0];
        row_next = y;
      end
    end

    image_width_next  = image_width;
    image_height_next = image_height;
    if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  image_width_next  = cfg_data[WIDTH_W-1:0];
        REG_HEIGHT: image_height_next = cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end

    // prefetch the upper-right entry of the next pixel
    w_nx  = eff_width(image_width_next);
    xn    = (CMP_W'(col_next) >= w_nx) ? '0 : CMP_W'(col_next);
    rd    = xn + CMP_W'(1);
    raddr = rd[COL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
      col          <= '0;
      row          <= '0;
    end else begin
      image_width  <= image_width_next;
      image_height <= image_height_next;
      col          <= col_next;
      row          <= row_next;
    end
  end

  `FSD_ASSERT_NEXT(a_col_in_row, step && !cfg_we, CMP_W'(col) < w_cur)
  `FSD_ASSERT_NEXT(a_row_in_frame, step && !cfg_we, row < h_cur)
  `FSD_ASSERT_NOW(a_reset_origin, $past(rst), col == '0 && row == '0)

endmodule

/* src/floyd_steinberg_dither_8color_top.sv */
// Eight-color Floyd-Steinberg ditherer for an RGB pixel stream in raster order.
// Input channel: in_valid/in_ready with red_in, green_in, blue_in.
// Output channel: out_valid/out_ready with red_out, green_out, blue_out (0 or
// 255 each) and palette_index; one output word for every input word, in order.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index 0 = width,
// 1 = height, cfg_data. Write it only while no pixel is in flight.
// An accepted pixel waits in the input stage register and moves to the output
// register when the output is empty or taken. Throughput is one pixel per cycle
// while out_ready stays high; the error diffusion, clamps and threshold all fit
// between the input stage register and the output register.
// The previous row's errors live in a one-port-write, one-port-read line
// buffer; the upper-right entry is prefetched for the next pixel, the above entry
// is the previous prefetch, and a same-cycle write to that address is bypassed.
// Reset clears the counters and sets width 640 and height 480; no clearing
// pass is needed because the first row never reads the buffer.
// When out_ready is low the output holds, the input stage still takes one
// more word, then in_ready drops until the output drains.
`include "floyd_steinberg_dither_8color_top_defines.svh"

module floyd_steinberg_dither_8color_top #(
  parameter int MAX_WIDTH = fsd_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fsd_pkg::PIX_W-1:0]      red_in,
  input  logic [fsd_pkg::PIX_W-1:0]      green_in,
  input  logic [fsd_pkg::PIX_W-1:0]      blue_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fsd_pkg::PIX_W-1:0]      red_out,
  output logic [fsd_pkg::PIX_W-1:0]      green_out,
  output logic [fsd_pkg::PIX_W-1:0]      blue_out,
  output logic [2:0]                     palette_index,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsd_pkg::CFG_DATA_W-1:0] cfg_data
);

  import fsd_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic             s1_valid;
  logic [PIX_W-1:0] s1_red, s1_green, s1_blue;
  logic             adv;

  pos_t             pos;
  logic [COL_W-1:0] x, raddr;
  logic [PACK_W-1:0] rdata, ur_data, above_sel, err_pack;
  logic [PACK_W-1:0] up_word, ul_word, left_word, first_word, fwd_data;
  logic             fwd;
  chan_en_t         en;
  logic [PIX_W-1:0] pix [3];
  logic [2:0]       hi;

  assign cfg_ready = 1'b1;
  assign adv       = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || adv;

  fsd_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (adv),
    .pos       (pos),
    .x         (x),
    .raddr     (raddr)
  );

  fsd_ram #(.WIDTH(PACK_W), .DEPTH(MAX_WIDTH)) u_line (
    .clk   (clk),
    .we    (adv),
    .waddr (x),
    .wdata (err_pack),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    ur_data   = fwd ? fwd_data : rdata;
    // column 0 has no prefetch of its own; keep its entry in a register
    above_sel = pos.top ? ((x == '0) ? first_word : up_word) : '0;
    en.use_ul = pos.top && pos.has_left;
    en.use_up = pos.top;
    en.use_ur = pos.has_ur;
    en.use_lf = pos.has_left;
  end

  assign pix[0] = s1_red;
  assign pix[1] = s1_green;
  assign pix[2] = s1_blue;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic signed [ERR_W-1:0] err_c;

    fsd_chan u_chan (
      .pix (pix[c]),
      .ul  ($signed(ul_word[ERR_W*c +: ERR_W])),
      .up  ($signed(above_sel[ERR_W*c +: ERR_W])),
      .ur  ($signed(ur_data[ERR_W*c +: ERR_W])),
      .lf  ($signed(left_word[ERR_W*c +: ERR_W])),
      .en  (en),
      .hi  (hi[c]),
      .err (err_c)
    );

    assign err_pack[ERR_W*c +: ERR_W] = err_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      fwd       <= 1'b0;
    end else begin
      s1_valid <= (in_valid && in_ready) || (s1_valid && !adv);
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // bypass a read that hits the entry written this cycle
      fwd <= adv && (raddr == x);
    end

    if (in_valid && in_ready) begin
      s1_red   <= red_in;
      s1_green <= green_in;
      s1_blue  <= blue_in;
    end

    fwd_data <= err_pack;

    if (adv) begin
      red_out       <= {PIX_W{hi[0]}};
      green_out     <= {PIX_W{hi[1]}};
      blue_out      <= {PIX_W{hi[2]}};
      palette_index <= PAL_INDEX[{hi[0], hi[1], hi[2]}];
      up_word       <= ur_data;
      ul_word       <= above_sel;
      left_word     <= err_pack;
      if (x == '0) begin
        first_word <= err_pack;
      end
    end
  end

  `FSD_ASSERT_NEXT(a_step_fills_out, adv, out_valid)
  `FSD_ASSERT_NEXT(a_held_word_kept, s1_valid && !adv, s1_valid)
  `FSD_ASSERT_NOW(a_full_stall_blocks, s1_valid && out_valid && !out_ready, !in_ready)

endmodule

/* test/dither_checker.sv */
`timescale 1ns / 100ps

module dither_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [fsd_pkg::PIX_W-1:0]      red_in,
  input  logic [fsd_pkg::PIX_W-1:0]      green_in,
  input  logic [fsd_pkg::PIX_W-1:0]      blue_in,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [fsd_pkg::PIX_W-1:0]      red_out,
  input  logic [fsd_pkg::PIX_W-1:0]      green_out,
  input  logic [fsd_pkg::PIX_W-1:0]      blue_out,
  input  logic [2:0]                     palette_index,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [fsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           drain_done,
  output int                             failures
);
  import fsd_pkg::*;

  localparam int COL_W = $clog2(DEF_MAX_WIDTH);

  typedef logic signed [ERR_W-1:0] err_t;

  typedef enum logic [2:0] {
    COLOR_BLACK  = 3'd0,
    COLOR_RED    = 3'd1,
    COLOR_GREEN  = 3'd2,
    COLOR_BLUE   = 3'd3,
    COLOR_YELLOW = 3'd4,
    COLOR_PINK   = 3'd5,
    COLOR_CYAN   = 3'd6,
    COLOR_WHITE  = 3'd7
  } color_e;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    color_e           color;
  } dithered_t;

  logic [WIDTH_W-1:0]                 width_reg;
  logic [HEIGHT_W-1:0]                height_reg;
  logic [COL_W-1:0]                   col_pos;
  logic [HEIGHT_W-1:0]                row_pos;
  err_t                               line_err [DEF_MAX_WIDTH][3];
  err_t                               upper_left [3];
  err_t                               left_err [3];
  dithered_t                          dithered_q [$];
  dithered_t                          want;
  int                                 mismatches = 0;
  logic                               leftover_done = 1'b0;

  assign failures = mismatches;

  // add one weighted neighbor error, truncated toward zero, then clamp
  function automatic int diffuse(input int level, input err_t err, input int weight);
    int sum;
    sum = level + (int'(err) * weight) / 16;
    if (sum < 0) return 0;
    if (sum > 255) return 255;
    return sum;
  endfunction

  function automatic color_e palette_of(input logic [2:0] corner);
    case (corner)
      3'b000:  return COLOR_BLACK;
      3'b100:  return COLOR_RED;
      3'b010:  return COLOR_GREEN;
      3'b001:  return COLOR_BLUE;
      3'b110:  return COLOR_YELLOW;
      3'b101:  return COLOR_PINK;
      3'b011:  return COLOR_CYAN;
      default: return COLOR_WHITE;
    endcase
  endfunction

  task automatic dither_pixel(input logic [PIX_W-1:0] r_lvl, input logic [PIX_W-1:0] g_lvl,
                              input logic [PIX_W-1:0] b_lvl);
    int               w;
    int               h;
    int               x;
    int               y;
    int               v;
    logic             top_row;
    logic             has_left;
    logic             has_ur;
    logic [PIX_W-1:0] level [3];
    err_t             above [3];
    err_t             ur_err [3];
    err_t             new_err [3];
    logic [2:0]       corner;
    dithered_t        res;
    level[0] = r_lvl;
    level[1] = g_lvl;
    level[2] = b_lvl;
    w = (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg);
    h = (height_reg == 0) ? 1 : int'(height_reg);
    x = int'(col_pos);
    y = int'(row_pos);
    // counters left beyond a shrunken frame restart the row or the frame
    if (x >= w) begin
      x = 0;
      y = y + 1;
    end
    if (y >= h) y = 0;
    top_row  = (y > 0);
    has_left = (x > 0);
    has_ur   = top_row && (x + 1 < w);
    for (int c = 0; c < 3; c++) begin
      above[c]  = top_row ? line_err[x][c] : '0;
      ur_err[c] = has_ur ? line_err[x + 1][c] : '0;
      v = int'(level[c]);
      if (top_row && has_left) v = diffuse(v, upper_left[c], 1);
      if (top_row) v = diffuse(v, above[c], 5);
      if (has_ur) v = diffuse(v, ur_err[c], 3);
      if (has_left) v = diffuse(v, left_err[c], 7);
      corner[2 - c] = (v >= 128);
      new_err[c] = err_t'(corner[2 - c] ? v - 255 : v);
    end
    for (int c = 0; c < 3; c++) begin
      upper_left[c]  = above[c];
      left_err[c]    = new_err[c];
      line_err[x][c] = new_err[c];
    end
    x = x + 1;
    if (x >= w) begin
      x = 0;
      y = y + 1;
      if (y >= h) y = 0;
    end
    col_pos = COL_W'(x);
    row_pos = HEIGHT_W'(y);
    res.red   = {PIX_W{corner[2]}};
    res.green = {PIX_W{corner[1]}};
    res.blue  = {PIX_W{corner[0]}};
    res.color = palette_of(corner);
    dithered_q.push_back(res);
  endtask

  task automatic check_field(input string field, input logic [7:0] exp_val,
                             input logic [7:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, exp_val, got_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      col_pos    = '0;
      row_pos    = '0;
      for (int c = 0; c < 3; c++) begin
        upper_left[c] = '0;
        left_err[c]   = '0;
      end
      dithered_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WIDTH) width_reg = cfg_data[WIDTH_W-1:0];
        else if (cfg_index == REG_HEIGHT) height_reg = cfg_data[HEIGHT_W-1:0];
      end
      if (in_valid && in_ready) dither_pixel(red_in, green_in, blue_in);
      if (out_valid && out_ready) begin
        if (dithered_q.size() == 0) begin
          $display("%0t: output word expected none, got %0d %0d %0d index %0d", $time,
                   red_out, green_out, blue_out, palette_index);
          mismatches++;
        end else begin
          want = dithered_q.pop_front();
          check_field("red_out", want.red, red_out);
          check_field("green_out", want.green, green_out);
          check_field("blue_out", want.blue, blue_out);
          check_field("palette_index", 8'(want.color), 8'(palette_index));
        end
      end
      if (drain_done && !leftover_done) begin
        leftover_done = 1'b1;
        if (dithered_q.size() != 0) begin
          $display("%0t: pending words expected 0, got %0d", $time, dithered_q.size());
          mismatches += dithered_q.size();
        end
      end
    end
  end

endmodule

/* test/tb_floyd_steinberg_dither_8color_top.sv */
`timescale 1ns / 100ps

module tb_floyd_steinberg_dither_8color_top;
  import fsd_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_PHASES = 12;
  localparam int FILL_PIXELS   = 360;
  localparam int WIDE_PIXELS   = 60;
  // line buffer entries written on row 0 before any random frame size
  localparam int FILLED_COLS   = FILL_PIXELS + WIDE_PIXELS;

  typedef enum int {
    PACE_FREE,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH
  } pace_e;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      red_in    = '0;
  logic [PIX_W-1:0]      green_in  = '0;
  logic [PIX_W-1:0]      blue_in   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      red_out;
  logic [PIX_W-1:0]      green_out;
  logic [PIX_W-1:0]      blue_out;
  logic [2:0]            palette_index;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  drain_done = 1'b0;
  int                    failures;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int hold_tag     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int words_in     = 0;
  int words_out    = 0;
  int quiet_cycles = 0;

  floyd_steinberg_dither_8color_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .red_in        (red_in),
    .green_in      (green_in),
    .blue_in       (blue_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .red_out       (red_out),
    .green_out     (green_out),
    .blue_out      (blue_out),
    .palette_index (palette_index),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  dither_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .red_in        (red_in),
    .green_in      (green_in),
    .blue_in       (blue_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .red_out       (red_out),
    .green_out     (green_out),
    .blue_out      (blue_out),
    .palette_index (palette_index),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .drain_done    (drain_done),
    .failures      (failures)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // a new hold_tag starts a long output stall; otherwise stall at random
  always @(posedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen <= hold_tag;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) words_out <= words_out + 1;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("tb_floyd_steinberg_dither_8color_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_pace(input pace_e pace);
    case (pace)
      PACE_FREE: begin
        idle_pct = 0;
        stall_pct <= 0;
      end
      PACE_SEND_IDLE: begin
        idle_pct = 48;
        stall_pct <= 0;
      end
      PACE_RECV_STALL: begin
        idle_pct = 0;
        stall_pct <= 48;
      end
      default: begin
        idle_pct = 11;
        stall_pct <= 11;
      end
    endcase
  endtask

  task automatic send_pixel(input logic [3*PIX_W-1:0] rgb);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {red_in, green_in, blue_in} <= rgb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_in++;
  endtask

  // drop valid and wait until every pixel sent has come back
  task automatic flush_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_out != words_in) @(posedge clk);
  endtask

  task automatic write_frame_size(input logic [CFG_DATA_W-1:0] w_data,
                                  input logic [CFG_DATA_W-1:0] h_data);
    cfg_valid <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= w_data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= h_data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] pick_level();
    logic [PIX_W-1:0] lvl;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: lvl = PIX_W'($urandom_range(255));
      5:             lvl = 8'h00;
      6:             lvl = 8'hFF;
      7:             lvl = $urandom_range(1) ? 8'h7F : 8'h80;
      default:       lvl = PIX_W'($urandom_range(136, 120));
    endcase
    return lvl;
  endfunction

  // widths stay within the filled part of the line buffer
  function automatic logic [CFG_DATA_W-1:0] pick_width();
    logic [CFG_DATA_W-1:0] w_data;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5, 6: w_data = CFG_DATA_W'($urandom_range(8, 1));
      7, 8:                w_data = CFG_DATA_W'($urandom_range(64, 9));
      default:             w_data = CFG_DATA_W'($urandom_range(FILLED_COLS));
    endcase
    w_data[CFG_DATA_W-1:WIDTH_W] = (CFG_DATA_W - WIDTH_W)'($urandom_range(15));
    return w_data;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_height();
    logic [CFG_DATA_W-1:0] h_data;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: h_data = CFG_DATA_W'($urandom_range(4, 1));
      6, 7:             h_data = CFG_DATA_W'($urandom_range(40, 5));
      8:                h_data = '0;
      default:          h_data = CFG_DATA_W'($urandom_range(65535));
    endcase
    return h_data;
  endfunction

  task automatic send_random_pixels(input int count);
    repeat (count) send_pixel({pick_level(), pick_level(), pick_level()});
  endtask

  initial begin
    int k;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first row at the reset size: no upper or left terms on the first word
    set_pace(PACE_FREE);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h7F807F);
    send_pixel(24'h807F80);
    flush_pipeline();

    // shrink mid-row: column 4 is past the new width, so the next word opens row 1
    write_frame_size(16'd3, 16'd2);
    send_pixel(24'hFF0000);
    send_pixel(24'h00FF00);
    send_pixel(24'h0000FF);
    send_pixel(24'hFFFF00);
    send_pixel(24'hFF00FF);
    send_pixel(24'h00FFFF);
    send_pixel(24'h808080);
    send_pixel(24'h7F7F7F);
    send_pixel(24'h404040);
    send_pixel(24'hC0C0C0);
    send_pixel(24'h010101);
    send_pixel(24'hFEFEFE);
    send_pixel(24'h800000);
    send_pixel(24'h007F00);
    send_pixel(24'hFF8000);
    send_pixel(24'h00007F);
    send_pixel(24'hA05FF0);
    send_pixel(24'h5FA00F);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    flush_pipeline();

    // zero width and height act as one: every word is its own frame
    set_pace(PACE_SEND_IDLE);
    write_frame_size(16'd0, 16'd0);
    send_random_pixels(30);
    flush_pipeline();

    // oversized width acts as the full line; stay on row 0 and fill the
    // leading entries of the line buffer that later frames read
    set_pace(PACE_BOTH);
    write_frame_size(16'hFFFF, 16'd2);
    send_random_pixels(FILL_PIXELS);
    flush_pipeline();

    set_pace(PACE_RECV_STALL);
    write_frame_size(16'd2048, 16'hFFFF);
    send_random_pixels(WIDE_PIXELS);
    flush_pipeline();

    for (k = 0; k < RANDOM_PHASES; k++) begin
      set_pace(pace_e'(k % 4));
      write_frame_size(pick_width(), pick_height());
      if (k == 4) hold_tag <= hold_tag + 1;
      send_random_pixels($urandom_range(50, 30));
      flush_pipeline();
    end

    repeat (8) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    if (failures == 0) begin
      $display("tb_floyd_steinberg_dither_8color_top OK");
    end else begin
      $display("tb_floyd_steinberg_dither_8color_top NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/fsd_pkg.sv
src/fsd_ram.sv
src/fsd_chan.sv
src/fsd_ctrl.sv
src/floyd_steinberg_dither_8color_top.sv
test/dither_checker.sv
test/tb_floyd_steinberg_dither_8color_top.sv
